// ===== rtl/svm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants of the stack machine execute unit
// Opcode numbers, action and status codes, widths and the divider interface.
// ----------------------------------------------------------------------------
package svm_pkg;

	localparam int MemWords  = 65536;
	localparam int CodeWords = 65536;
	localparam int MemAw     = $clog2(MemWords);
	localparam int CodeAw    = $clog2(CodeWords);
	localparam int PtrW      = 19;
	localparam int PcOutW    = 16;

	localparam logic [1:0] ACT_PRELOAD = 2'd0;
	localparam logic [1:0] ACT_START   = 2'd1;
	localparam logic [1:0] ACT_EXEC    = 2'd2;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_EXIT   = 3'd1;
	localparam logic [2:0] ST_HOST   = 3'd2;
	localparam logic [2:0] ST_BADOP  = 3'd3;
	localparam logic [2:0] ST_DIVZ   = 3'd4;
	localparam logic [2:0] ST_IDLE   = 3'd5;

	localparam logic [5:0] OP_IMM = 6'd0,  OP_LEA = 6'd1,  OP_JMP = 6'd2,  OP_JSR = 6'd3;
	localparam logic [5:0] OP_BZ  = 6'd4,  OP_BNZ = 6'd5,  OP_ENT = 6'd6,  OP_ADJ = 6'd7;
	localparam logic [5:0] OP_LEV = 6'd8,  OP_LI  = 6'd9,  OP_LC  = 6'd10, OP_SI  = 6'd11;
	localparam logic [5:0] OP_SC  = 6'd12, OP_PSH = 6'd13, OP_OR  = 6'd14, OP_XOR = 6'd15;
	localparam logic [5:0] OP_AND = 6'd16, OP_EQ  = 6'd17, OP_NE  = 6'd18, OP_LT  = 6'd19;
	localparam logic [5:0] OP_GT  = 6'd20, OP_LE  = 6'd21, OP_GE  = 6'd22, OP_SHL = 6'd23;
	localparam logic [5:0] OP_SHR = 6'd24, OP_ADD = 6'd25, OP_SUB = 6'd26, OP_MUL = 6'd27;
	localparam logic [5:0] OP_DIV = 6'd28, OP_MOD = 6'd29, OP_H0  = 6'd30, OP_H7  = 6'd37;
	localparam logic [5:0] OP_EXIT = 6'd38;

	typedef struct packed {
		logic        start;
		logic        is_mod;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] value;
	} div_rsp_t;

endpackage

// ===== rtl/svm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_div: signed radix-2 divider
// One quotient bit per cycle; gives the signed quotient or remainder.
// ----------------------------------------------------------------------------
module svm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  svm_pkg::div_req_t req,
	output svm_pkg::div_rsp_t rsp
);
	import svm_pkg::*;

	logic [31:0] rem_q, quo_q, dsr_q;
	logic        neg_q, is_mod_q, busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;
	logic [31:0] rem_sh;

	assign rem_sh = {rem_q[30:0], quo_q[31]};
	assign trial  = {1'b0, rem_sh} - {1'b0, dsr_q};

	// iterate one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q    <= '0;
			quo_q    <= req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
			dsr_q    <= req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
			neg_q    <= req.is_mod ? req.dividend[31] : (req.dividend[31] ^ req.divisor[31]);
			is_mod_q <= req.is_mod;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = is_mod_q ? (neg_q ? 32'd0 - rem_q : rem_q)
	                            : (neg_q ? 32'd0 - quo_q : quo_q);
endmodule

// ===== rtl/stack_vm_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_vm_execute_unit: execute stage of a 32-bit accumulator/stack machine
// Takes preload, start and execute items and returns one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) carries action, opcode, operand and
//   address. The output channel (out_valid/out_stall) returns status, next_pc,
//   accumulator, stack_pointer and exit_code, one result per item.
//   stack_top must be written (cfg_we/cfg_data) only while the unit is idle; not enforced.
// Timing:
//   Data memory is one single-port synchronous RAM with a registered read.
//   An item taking no memory read passes EXEC then OUT; one reading memory
//   (pop, load, EXIT) adds RD1; a byte store or LEAVE (two reads) adds RD2,
//   MUL adds WB, DIV/MOD by nonzero adds DIV (bit-serial divider). One item
//   at a time: the next item is taken in the cycle after the result transfers.
// Reset:
//   pc, accumulator and flags clear, sp and bp take stack_top; memory
//   contents are undefined until preloaded or written by the program.
// Stall:
//   The result sits in the output register; a new item is taken as soon as
//   the previous result has transferred.
// ----------------------------------------------------------------------------
module stack_vm_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [18:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [5:0]  opcode,
	input  logic [31:0] operand,
	input  logic [17:0] address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] next_pc,
	output logic [31:0] accumulator,
	output logic [18:0] stack_pointer,
	output logic [31:0] exit_code
);
	import svm_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EXEC = 7'b0000010,
		S_RD1  = 7'b0000100,
		S_RD2  = 7'b0001000,
		S_DIV  = 7'b0010000,
		S_WB   = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic [PtrW-1:0]   top_q, sp_q, bp_q;
	logic [CodeAw-1:0] pc_q;
	logic [31:0]       acc_q;
	logic              run_q;
	logic [1:0]        act_q;
	logic [5:0]        op_q;
	logic [31:0]       opd_q, pop1_q, exit_q;
	logic [2:0]        st_q;

	// data memory
	logic [31:0]       mem [MemWords];
	logic              m_we;
	logic [MemAw-1:0]  m_addr;
	logic [31:0]       m_wdata, m_rdata;

	always_ff @(posedge clk) begin
		if (m_we) mem[m_addr] <= m_wdata;
		m_rdata <= mem[m_addr];
	end

	div_req_t dreq;
	div_rsp_t drsp;
	svm_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic in_xfer, out_xfer;
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	function automatic logic [MemAw-1:0] waddr(input logic [31:0] a);
		return a[MemAw+1:2];
	endfunction

	// combinational helpers
	logic [CodeAw-1:0] pc1, pc2, tgt, pc_exec;
	logic [PtrW-1:0]   sp_dn, sp_up, opd4;
	logic [31:0]       b_val, alu, shr_v;
	logic [4:0]        sh;
	logic              lt_ba, lt_ab, take_br, needs_rd;
	logic [4:0]        bsel;

	assign pc1   = pc_q + CodeAw'(1);
	assign pc2   = pc_q + CodeAw'(2);
	assign tgt   = opd_q[CodeAw-1:0];
	assign sp_dn = sp_q - PtrW'(4);
	assign sp_up = sp_q + PtrW'(4);
	assign opd4  = PtrW'({opd_q, 2'b00});
	// popped word comes straight from memory in the first read cycle
	assign b_val = (state_q == S_RD1) ? m_rdata : pop1_q;
	assign sh    = acc_q[4:0];
	assign lt_ba = $signed(b_val) < $signed(acc_q);
	assign lt_ab = $signed(acc_q) < $signed(b_val);
	assign shr_v = 32'($signed(b_val) >>> sh);
	assign bsel  = {pop1_q[1:0], 3'b000};

	// next pc of an executed instruction
	assign take_br = (op_q == OP_JMP) || (op_q == OP_JSR) ||
	                 (op_q == OP_BZ && acc_q == 32'd0) || (op_q == OP_BNZ && acc_q != 32'd0);
	assign pc_exec = take_br ? tgt : ((op_q <= OP_ADJ) ? pc2 : pc1);

	// instructions that read memory after the execute cycle
	assign needs_rd = (op_q >= OP_LEV && op_q <= OP_MOD && op_q != OP_PSH) ||
	                  (op_q == OP_EXIT);

	// byte from the word just read, at low bits of a given address
	function automatic logic [31:0] sext8(input logic [31:0] w, input logic [1:0] lo);
		logic [7:0] b;
		b = 8'(w >> {lo, 3'b000});
		return {{24{b[7]}}, b};
	endfunction

	always_comb begin
		case (op_q)
			OP_OR:  alu = b_val | acc_q;
			OP_XOR: alu = b_val ^ acc_q;
			OP_AND: alu = b_val & acc_q;
			OP_EQ:  alu = 32'(b_val == acc_q);
			OP_NE:  alu = 32'(b_val != acc_q);
			OP_LT:  alu = 32'(lt_ba);
			OP_GT:  alu = 32'(lt_ab);
			OP_LE:  alu = 32'(!lt_ab);
			OP_GE:  alu = 32'(!lt_ba);
			OP_SHL: alu = b_val << sh;
			OP_SHR: alu = shr_v;
			OP_ADD: alu = b_val + acc_q;
			OP_SUB: alu = b_val - acc_q;
			OP_MUL: alu = b_val * acc_q;
			default: alu = acc_q;
		endcase
	end

	// memory port and divider requests
	always_comb begin
		m_we    = 1'b0;
		m_addr  = waddr(32'(sp_q));
		m_wdata = acc_q;
		dreq.start    = 1'b0;
		dreq.is_mod   = (op_q == OP_MOD);
		dreq.dividend = m_rdata;
		dreq.divisor  = acc_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer && action == ACT_PRELOAD) begin
					m_we    = 1'b1;
					m_addr  = waddr(32'(address));
					m_wdata = operand;
				end
			end
			S_EXEC: begin
				if (act_q == ACT_EXEC && run_q) begin
					case (op_q)
						OP_JSR: begin
							m_we = 1'b1; m_addr = waddr(32'(sp_dn));
							m_wdata = 32'(pc2);
						end
						OP_ENT: begin
							m_we = 1'b1; m_addr = waddr(32'(sp_dn));
							m_wdata = 32'(bp_q);
						end
						OP_PSH: begin
							m_we = 1'b1; m_addr = waddr(32'(sp_dn));
							m_wdata = acc_q;
						end
						OP_LEV: m_addr = waddr(32'(bp_q));
						OP_LI, OP_LC: m_addr = waddr(acc_q);
						default: m_addr = waddr(32'(sp_q));
					endcase
				end
			end
			S_RD1: begin
				// second access: LEAVE pops return pc, SI writes and SC reads the target word; DIV/MOD start the divider
				if (op_q == OP_LEV) m_addr = waddr(32'(sp_q));
				else if (op_q == OP_SI) begin
					m_we = 1'b1; m_addr = waddr(m_rdata); m_wdata = acc_q;
				end else m_addr = waddr(m_rdata);
				if ((op_q == OP_DIV || op_q == OP_MOD) && acc_q != 32'd0)
					dreq.start = 1'b1;
			end
			S_RD2: begin
				if (op_q == OP_SC) begin
					m_we    = 1'b1;
					m_addr  = waddr(pop1_q);
					m_wdata = (m_rdata & ~(32'hFF << bsel)) | (32'(acc_q[7:0]) << bsel);
				end
			end
			S_DIV, S_WB, S_OUT: ;
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_xfer) state_d = S_EXEC;
			S_EXEC: begin
				state_d = S_OUT;
				if (act_q == ACT_EXEC && run_q && needs_rd) state_d = S_RD1;
			end
			S_RD1: begin
				case (op_q)
					OP_LEV, OP_SC: state_d = S_RD2;
					OP_MUL: state_d = S_WB;
					OP_DIV, OP_MOD: state_d = (acc_q != 32'd0) ? S_DIV : S_OUT;
					default: state_d = S_OUT;
				endcase
			end
			S_RD2: state_d = S_OUT;
			S_DIV: if (drsp.done) state_d = S_OUT;
			S_WB: state_d = S_OUT;
			S_OUT: if (out_xfer) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			top_q   <= PtrW'(262144);
			sp_q    <= PtrW'(262144);
			bp_q    <= PtrW'(262144);
			pc_q    <= '0;
			acc_q   <= '0;
			run_q   <= 1'b0;
		end else begin
			if (cfg_we) top_q <= cfg_data;
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: ;
				S_EXEC: begin
					if (act_q == ACT_START) begin
						pc_q  <= opd_q[CodeAw-1:0];
						sp_q  <= PtrW'(pop1_q);
						bp_q  <= top_q;
						run_q <= 1'b1;
					end else if (act_q == ACT_EXEC && run_q) begin
						pc_q <= pc_exec;
						case (op_q)
							OP_IMM: acc_q <= opd_q;
							OP_LEA: acc_q <= 32'(bp_q) + {opd_q[29:0], 2'b00};
							OP_JMP, OP_BZ, OP_BNZ: ;
							OP_JSR: sp_q <= sp_dn;
							OP_ENT: begin
								bp_q <= sp_dn;
								sp_q <= sp_dn - opd4;
							end
							OP_ADJ: sp_q <= sp_q + opd4;
							OP_PSH: sp_q <= sp_dn;
							OP_LEV: sp_q <= bp_q + PtrW'(4);
							OP_LI, OP_LC: ;
							default: begin
								if (op_q >= OP_SI && op_q <= OP_MOD && op_q != OP_PSH) begin
									sp_q <= sp_up;
								end else if (op_q == OP_EXIT) begin
									run_q <= 1'b0;
								end else if (!(op_q >= OP_H0 && op_q <= OP_H7)) begin
									run_q <= 1'b0;
								end
							end
						endcase
					end
				end
				S_RD1: begin
					case (op_q)
						OP_LEV: begin
							bp_q <= PtrW'(m_rdata);
							sp_q <= sp_up;
						end
						OP_LI: acc_q <= m_rdata;
						OP_LC: acc_q <= sext8(m_rdata, acc_q[1:0]);
						// multiply takes the registered popped word in the next cycle
						OP_SI, OP_SC, OP_MUL, OP_DIV, OP_MOD, OP_EXIT: ;
						default: acc_q <= alu;
					endcase
				end
				S_RD2: begin
					if (op_q == OP_LEV) pc_q <= m_rdata[CodeAw-1:0];
					else acc_q <= {{24{acc_q[7]}}, acc_q[7:0]};
				end
				S_DIV: begin
					if (drsp.done) acc_q <= drsp.value;
				end
				S_WB: acc_q <= alu;
				S_OUT: ;
				default: ;
			endcase
		end
	end

	// item payload, popped word and result fields
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			act_q  <= action;
			op_q   <= opcode;
			opd_q  <= operand;
			pop1_q <= 32'(address);
			st_q   <= ST_OK;
			exit_q <= '0;
		end
		if (state_q == S_EXEC) begin
			if (act_q[1] && (act_q[0] || !run_q)) st_q <= ST_IDLE;
			else if (act_q == ACT_EXEC) begin
				if (op_q >= OP_H0 && op_q <= OP_H7) st_q <= ST_HOST;
				else if (op_q == OP_EXIT) st_q <= ST_EXIT;
				else if (op_q > OP_EXIT) st_q <= ST_BADOP;
			end
		end
		if (state_q == S_RD1) begin
			pop1_q <= m_rdata;
			if (op_q == OP_EXIT) exit_q <= m_rdata;
			if ((op_q == OP_DIV || op_q == OP_MOD) && acc_q == 32'd0) st_q <= ST_DIVZ;
		end
	end

	assign status        = st_q;
	assign next_pc       = PcOutW'(pc_q);
	assign accumulator   = acc_q;
	assign stack_pointer = sp_q;
	assign exit_code     = exit_q;
endmodule

// ===== rtl/svm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_checker: port-level checks of the execute unit
// Watches handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module svm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [31:0] exit_code
);
	import svm_pkg::*;

	// a waiting result holds its status
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("result changed while stalled");

	// no intake while a result waits
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	// exit code only on exit
	a_exit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_EXIT |-> exit_code == 32'd0)
		else $error("exit code outside exit");

	// status code in range
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_IDLE)
		else $error("bad status");
endmodule

bind stack_vm_execute_unit svm_checker u_svm_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.exit_code(exit_code)
);
